>>> src/assert_macros.svh
// Assertion macros for the port-level checker file.
// Each macro wraps one concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> src/npf_pkg.sv
// Package for the next prime finder: field widths and the remainder unit status.
// No dependencies.
`timescale 1ns / 1ps

package npf_pkg;

  // Field width of the number and the result
  localparam int FIELD_W = 32;
  // Candidate carries one extra bit so it can step past the bound
  localparam int CAND_W  = FIELD_W + 1;
  // Trial divisor never exceeds 2^16 for a 32-bit candidate
  localparam int DIV_W   = 17;
  // Square of the divisor, with room for the step past the candidate
  localparam int SQ_W    = 2 * DIV_W;
  // Default result width bound
  localparam int NPF_WIDTH = 32;

  // Status returned by the remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } npf_rem_status_t;

endpackage

>>> src/npf_rem_unit.sv
// Iterative remainder unit: loads on start, then one restoring step per cycle (FIELD_W steps).
// Depends on npf_pkg.
`timescale 1ns / 1ps

module npf_rem_unit
  import npf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [FIELD_W-1:0]   dividend,
  input  logic [DIV_W-1:0]     divisor,
  output npf_rem_status_t      status
);

  localparam int CNT_W = $clog2(FIELD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FIELD_W - 1);

  logic                busy;
  logic                done;
  logic                zero;
  logic [CNT_W-1:0]    count;
  logic [FIELD_W-1:0]  shreg;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    dvs;
  logic [DIV_W:0]      trial;
  logic [DIV_W-1:0]    rem_next;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    trial = {rem, shreg[FIELD_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = DIV_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[DIV_W-1:0];
    end
  end

  // Hold operands and advance one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        shreg <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        shreg <= shreg << 1;
        rem   <= rem_next;
        count <= count + CNT_W'(1);
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
          zero <= (rem_next == '0);
        end
      end
    end
  end

  assign status.done = done;
  assign status.zero = zero;

endmodule

>>> src/next_prime_finder_unit.sv
// Searches for the next prime after the input. Each candidate c is tried against trial
// divisors from two upward (floor(sqrt(c)) - 1 of them for a prime, smallest factor less
// one for a composite, none above the bound, which ends the search with overflow); each
// divisor is issued in turn to the remainder unit. One item at a time: in_ready low from
// acceptance until the result beat is taken. Synchronous active-high reset returns to
// idle with no result pending; the result registers are not reset.
`timescale 1ns / 1ps

module next_prime_finder_unit
  import npf_pkg::*;
#(
  parameter int WIDTH = NPF_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FIELD_W-1:0]  start_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FIELD_W-1:0]  prime,
  output logic                overflow
);

  // Largest result allowed: 2^min(WIDTH, FIELD_W) - 1
  localparam int LIMIT_BITS = (WIDTH > FIELD_W) ? FIELD_W : WIDTH;
  localparam logic [CAND_W-1:0] LIMIT = (CAND_W'(1) << LIMIT_BITS) - CAND_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_TEST,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state;
  logic [CAND_W-1:0]    candidate;
  logic [DIV_W-1:0]     divisor;
  logic [SQ_W-1:0]      square;
  logic                 rem_start;
  npf_rem_status_t      rem_status;
  logic [CAND_W-1:0]    first_cand;

  // First candidate is n + 1, raised to 2
  always_comb begin
    first_cand = {1'b0, start_value} + CAND_W'(1);
    if (first_cand < CAND_W'(2)) begin
      first_cand = CAND_W'(2);
    end
  end

  // Sequence candidates and trial divisors
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rem_start <= 1'b0;
    end else begin
      rem_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            candidate <= first_cand;
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (candidate > LIMIT) begin
            prime    <= '0;
            overflow <= 1'b1;
            state    <= S_DONE;
          end else begin
            divisor <= DIV_W'(2);
            square  <= SQ_W'(4);
            state   <= S_TEST;
          end
        end
        S_TEST: begin
          if (square > SQ_W'(candidate)) begin
            prime    <= candidate[FIELD_W-1:0];
            overflow <= 1'b0;
            state    <= S_DONE;
          end else begin
            rem_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_status.done) begin
            if (rem_status.zero) begin
              candidate <= candidate + CAND_W'(1);
              state     <= S_NEXT;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              square  <= square + SQ_W'({divisor, 1'b0}) + SQ_W'(1);
              divisor <= divisor + DIV_W'(1);
              state   <= S_TEST;
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  npf_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (candidate[FIELD_W-1:0]),
    .divisor  (divisor),
    .status   (rem_status)
  );

endmodule

>>> src/npf_checker.sv
// Port-level checker for the next prime finder, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module npf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] prime,
  input logic        overflow
);

  // Overflow beat carries a zero prime
  `ASSERT_IMPL(a_ovf_zero, clk, rst, out_valid && overflow, prime == 32'd0)

  // A found prime is two or odd
  `ASSERT_IMPL(a_prime_odd, clk, rst, out_valid && !overflow, prime[0] || prime == 32'd2)

  // No new beat is taken while a result waits
  `ASSERT_IMPL(a_one_item, clk, rst, out_valid, !in_ready)

  // Drop ready once a beat is taken
  `ASSERT_NEXT(a_busy_after, clk, rst, in_valid && in_ready, !in_ready)

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
               out_valid && $stable(prime) && $stable(overflow))

endmodule

bind next_prime_finder_unit npf_checker u_npf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .prime       (prime),
  .overflow    (overflow)
);

>>> sim/next_prime_finder_unit_checker.sv
// Checker for the next prime finder: watches both beat channels, predicts each result.
// Depends on npf_pkg for the field width; hands its mismatch and backlog counts to the bench.
`timescale 1ns / 1ps

module next_prime_finder_unit_checker
  import npf_pkg::*;
#(
  parameter int WIDTH = NPF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FIELD_W-1:0] start_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [FIELD_W-1:0] prime,
  input  logic               overflow,
  output int                 error_count,
  output int                 outstanding
);

  typedef struct packed {
    logic [FIELD_W-1:0] prime;
    logic               overflow;
  } prime_result_t;

  prime_result_t expected_primes[$];

  // Search upward from n+1 (never below two) by trial division up to the square root
  function automatic prime_result_t next_prime_of(input logic [FIELD_W-1:0] n);
    longint unsigned bound;
    longint unsigned cand;
    longint unsigned d;
    bit              composite;
    prime_result_t   res;
    if (WIDTH >= FIELD_W) begin
      bound = (64'd1 << FIELD_W) - 64'd1;
    end else begin
      bound = (64'd1 << WIDTH) - 64'd1;
    end
    cand = {32'd0, n} + 64'd1;
    if (cand < 64'd2) begin
      cand = 64'd2;
    end
    res.prime    = '0;
    res.overflow = 1'b1;
    while (cand <= bound && res.overflow) begin
      composite = 1'b0;
      for (d = 64'd2; d * d <= cand && !composite; d++) begin
        if (cand % d == 64'd0) begin
          composite = 1'b1;
        end
      end
      if (!composite) begin
        res.prime    = cand[FIELD_W-1:0];
        res.overflow = 1'b0;
      end else begin
        cand++;
      end
    end
    return res;
  endfunction

  // Queue a prediction per accepted number, compare each result beat with the oldest
  always @(posedge clk) begin
    prime_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_primes.push_back(next_prime_of(start_value));
      end
      if (out_valid && out_ready) begin
        if (expected_primes.size() == 0) begin
          $error("unexpected result beat: prime=%0d overflow=%0b", prime, overflow);
          error_count++;
        end else begin
          want = expected_primes.pop_front();
          if (prime !== want.prime) begin
            $error("prime: expected %0d, actual %0d", want.prime, prime);
            error_count++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
            error_count++;
          end
        end
      end
      outstanding = expected_primes.size();
    end
  end

endmodule

>>> sim/next_prime_finder_unit_tb.sv
// Bench top for the next prime finder: clock, reset, number stimulus and the verdict.
// Depends on npf_pkg, next_prime_finder_unit and next_prime_finder_unit_checker.
`timescale 1ns / 1ps

module next_prime_finder_unit_tb;
  import npf_pkg::*;

  localparam int RESULT_W = NPF_WIDTH;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] start_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] prime;
  logic               overflow;

  int                 error_count;
  int                 outstanding;
  idle_mode_t         idle_mode = IDLE_NONE;

  logic [FIELD_W-1:0] directed_numbers[] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd7, 32'd8, 32'd13, 32'd23, 32'd89,
    32'd113, 32'd1000, 32'd65520, 32'd65535,
    32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  next_prime_finder_unit #(
    .WIDTH(RESULT_W)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_value(start_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime      (prime),
    .overflow   (overflow)
  );

  next_prime_finder_unit_checker #(
    .WIDTH(RESULT_W)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_value(start_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime      (prime),
    .overflow   (overflow),
    .error_count(error_count),
    .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel at random in the receiver phases
  always @(posedge clk) begin
    if (idle_mode == IDLE_RECEIVER) begin
      out_ready <= ($urandom_range(99) >= 77);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(99) >= 32);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one number, idling first in the sender phases, and hold it until accepted
  task automatic send_number(input logic [FIELD_W-1:0] n);
    int unsigned idle_pct;
    idle_pct = (idle_mode == IDLE_BOTH) ? 32 : 77;
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    start_value <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int unsigned pick;
    logic [FIELD_W-1:0] n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small numbers, prime gaps, numbers near 2^16, overflow at the top
    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i]);
    end

    // Random: mostly small numbers so searches stay short, a few large and overflow cases
    for (int phase = 0; phase < 4; phase++) begin
      idle_mode <= idle_mode_t'(phase);
      for (int k = 0; k < 21; k++) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          n = $urandom_range(255);
        end else if (pick < 90) begin
          n = $urandom_range(4095, 256);
        end else if (pick < 97) begin
          n = $urandom_range(65535, 4096);
        end else begin
          n = 32'hFFFF_FFFD + $urandom_range(2);
        end
        send_number(n);
      end
    end

    // Drain: wait out every expected result, then a short settle
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);

    if (error_count == 0 && outstanding == 0) begin
      $display("next_prime_finder_unit verification clean");
    end else begin
      $display("next_prime_finder_unit verification failed");
    end
    $finish;
  end

  // Timeout well beyond the slowest correct run
  initial begin
    #48_000_000;
    $display("next_prime_finder_unit verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/npf_pkg.sv
src/npf_rem_unit.sv
src/next_prime_finder_unit.sv
src/npf_checker.sv
sim/next_prime_finder_unit_checker.sv
sim/next_prime_finder_unit_tb.sv
